// ----- rtl/dssb_pkg.sv -----
package dssb_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int VAL_W  = 32;
  localparam int CFG_W  = 7;
  localparam int SIZE_W = 7;
  localparam int POS_W  = 6;

  typedef enum logic [2:0] {
    ACT_PUSH   = 3'd0,
    ACT_POP    = 3'd1,
    ACT_PEEK   = 3'd2,
    ACT_SEARCH = 3'd3,
    ACT_CLEAR  = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN
  } st_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture side and key of the new request
    logic push;       // write the key on top of the requested side
    logic clear;      // empty the requested side
    logic rd_top;     // read the top entry of the requested side
    logic scan_next;  // step the scan one entry toward the bottom
    logic finish;     // issue the result
    logic ok;
    logic use_data;
    logic use_pos;
    logic dec;        // pop the latched side
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;      // requested side holds nothing
    logic room;       // combined count below capacity
    logic hit;        // scanned word equals the key
    logic idx_zero;   // scan reached the bottom entry
  } stat_t;

  function automatic logic [DATA_W-1:0] to_word(input logic signed [VAL_W-1:0] v);
    return DATA_W'(v);
  endfunction

  function automatic logic [AW-1:0] ent_addr(input logic side, input logic [CW-1:0] i,
                                             input logic [CW-1:0] cap);
    logic [CW-1:0] t;
    t = side ? (cap - CW'(1) - i) : i;
    return t[AW-1:0];
  endfunction

endpackage

// ----- rtl/dssb_ctrl.sv -----
module dssb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [2:0]          in_action,
  input  dssb_pkg::stat_t     stat,
  output dssb_pkg::cmd_t      cmd,
  output logic                busy
);

  dssb_pkg::st_t  state_r, state_nxt;
  dssb_pkg::act_t act_r, act_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dssb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt;
  end

  assign busy = (state_r != dssb_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    act_nxt   = act_r;
    cmd       = '0;
    unique case (state_r)
      dssb_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          act_nxt  = dssb_pkg::act_t'(in_action);
          unique case (in_action) inside
            dssb_pkg::ACT_PUSH: begin
              cmd.push   = stat.room;
              cmd.finish = 1'b1;
              cmd.ok     = stat.room;
            end
            dssb_pkg::ACT_POP, dssb_pkg::ACT_PEEK: begin
              if (stat.empty) begin
                cmd.finish = 1'b1;
              end else begin
                cmd.rd_top = 1'b1;
                state_nxt  = dssb_pkg::ST_READ;
              end
            end
            dssb_pkg::ACT_SEARCH: begin
              if (stat.empty) begin
                cmd.finish = 1'b1;
              end else begin
                cmd.rd_top = 1'b1;
                state_nxt  = dssb_pkg::ST_SCAN;
              end
            end
            dssb_pkg::ACT_CLEAR: begin
              cmd.clear  = 1'b1;
              cmd.finish = 1'b1;
              cmd.ok     = 1'b1;
            end
            default: begin
              cmd.finish = 1'b1;
            end
          endcase
        end
      end
      dssb_pkg::ST_READ: begin
        cmd.finish   = 1'b1;
        cmd.ok       = 1'b1;
        cmd.use_data = 1'b1;
        cmd.dec      = (act_r == dssb_pkg::ACT_POP);
        state_nxt    = dssb_pkg::ST_IDLE;
      end
      dssb_pkg::ST_SCAN: begin
        if (stat.hit) begin
          cmd.finish  = 1'b1;
          cmd.ok      = 1'b1;
          cmd.use_pos = 1'b1;
          state_nxt   = dssb_pkg::ST_IDLE;
        end else if (stat.idx_zero) begin
          cmd.finish = 1'b1;
          state_nxt  = dssb_pkg::ST_IDLE;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      default: begin
        state_nxt = dssb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/dssb_dp.sv -----
module dssb_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_side,
  input  logic signed [dssb_pkg::VAL_W-1:0]    in_value,
  input  logic                                 cfg_we,
  input  logic [dssb_pkg::CFG_W-1:0]           cfg_wdata,
  input  dssb_pkg::cmd_t                       cmd,
  output dssb_pkg::stat_t                      stat,
  output logic                                 out_valid,
  output logic                                 out_status,
  output logic signed [dssb_pkg::VAL_W-1:0]    out_data,
  output logic [dssb_pkg::POS_W-1:0]           out_position,
  output logic [dssb_pkg::SIZE_W-1:0]          out_size_a,
  output logic [dssb_pkg::SIZE_W-1:0]          out_size_b,
  output logic                                 out_full_res
);

  localparam int CW = dssb_pkg::CW;
  localparam int AW = dssb_pkg::AW;
  localparam int DW = dssb_pkg::DATA_W;
  localparam int EW = (CW > dssb_pkg::CFG_W) ? CW : dssb_pkg::CFG_W;

  logic [DW-1:0] mem [dssb_pkg::DEPTH];
  logic [DW-1:0] rd_q_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  logic [CW-1:0] cap_r;
  logic [CW-1:0] cnt_a_r, cnt_b_r;
  logic [CW-1:0] cnt_a_nxt, cnt_b_nxt;
  logic [CW-1:0] cnt_in;
  logic [AW-1:0] idx_r;
  logic [DW-1:0] key_r;
  logic          side_r;

  logic                              valid_r;
  logic                              status_r;
  logic signed [dssb_pkg::VAL_W-1:0] data_r;
  logic [dssb_pkg::POS_W-1:0]        pos_r;
  logic [dssb_pkg::SIZE_W-1:0]       size_a_r, size_b_r;
  logic                              full_r;

  logic [EW-1:0] cfg_ext;
  logic [CW:0]   total_now, total_nxt;

  assign cnt_in    = in_side ? cnt_b_r : cnt_a_r;
  assign total_now = {1'b0, cnt_a_r} + {1'b0, cnt_b_r};
  assign total_nxt = {1'b0, cnt_a_nxt} + {1'b0, cnt_b_nxt};

  assign wr_addr = dssb_pkg::ent_addr(in_side, cnt_in, cap_r);
  assign rd_addr = cmd.rd_top
                 ? dssb_pkg::ent_addr(in_side, cnt_in - CW'(1), cap_r)
                 : dssb_pkg::ent_addr(side_r, CW'(idx_r) - CW'(1), cap_r);

  assign stat.empty    = (cnt_in == '0);
  assign stat.room     = (total_now < {1'b0, cap_r});
  assign stat.hit      = (rd_q_r == key_r);
  assign stat.idx_zero = (idx_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= dssb_pkg::to_word(in_value);
    end
    rd_q_r <= mem[rd_addr];
  end

  always_comb begin
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    if (cmd.push) begin
      if (in_side) cnt_b_nxt = cnt_b_r + CW'(1);
      else         cnt_a_nxt = cnt_a_r + CW'(1);
    end
    if (cmd.clear) begin
      if (in_side) cnt_b_nxt = '0;
      else         cnt_a_nxt = '0;
    end
    if (cmd.dec) begin
      if (side_r) cnt_b_nxt = cnt_b_r - CW'(1);
      else        cnt_a_nxt = cnt_a_r - CW'(1);
    end
  end

  assign cfg_ext = EW'(cfg_wdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CW'(dssb_pkg::DEPTH);
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      valid_r <= 1'b0;
    end else begin
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
      valid_r <= cmd.finish;
      // capacity only moves while both sides are empty; clamp to 1..DEPTH
      if (cfg_we && cnt_a_r == '0 && cnt_b_r == '0) begin
        if (cfg_ext == '0) begin
          cap_r <= CW'(1);
        end else if (cfg_ext > EW'(dssb_pkg::DEPTH)) begin
          cap_r <= CW'(dssb_pkg::DEPTH);
        end else begin
          cap_r <= CW'(cfg_ext);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      side_r <= in_side;
      key_r  <= dssb_pkg::to_word(in_value);
    end
    if (cmd.rd_top) begin
      idx_r <= AW'(cnt_in - CW'(1));
    end else if (cmd.scan_next) begin
      idx_r <= idx_r - AW'(1);
    end
    if (cmd.finish) begin
      status_r <= ~cmd.ok;
      data_r   <= cmd.use_data ? dssb_pkg::VAL_W'(rd_q_r) : '0;
      pos_r    <= cmd.use_pos ? dssb_pkg::POS_W'(idx_r) : '0;
      size_a_r <= dssb_pkg::SIZE_W'(cnt_a_nxt);
      size_b_r <= dssb_pkg::SIZE_W'(cnt_b_nxt);
      full_r   <= (total_nxt == {1'b0, cap_r});
    end
  end

  assign out_valid    = valid_r;
  assign out_status   = status_r;
  assign out_data     = data_r;
  assign out_position = pos_r;
  assign out_size_a   = size_a_r;
  assign out_size_b   = size_b_r;
  assign out_full_res = full_r;

endmodule

// ----- rtl/dual_stack_shared_buffer.sv -----
// Two stacks sharing one 64-word store, A from the bottom, B from the top.
// Push, clear, unknown actions and pop, peek or search on an empty side: result
// in the cycle after start, next start accepted in the following cycle.
// Pop and peek: registered store read, result registered from ST_READ; busy in ST_READ.
// Search: entries walked top-down in ST_SCAN, one store read per cycle; busy
// stays high for the walk.
// Synchronous active-low reset empties both stacks and sets capacity to 64.
module dual_stack_shared_buffer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [2:0]                           in_action,
  input  logic                                 in_side,
  input  logic signed [dssb_pkg::VAL_W-1:0]    in_value,
  input  logic                                 cfg_we,
  input  logic [dssb_pkg::CFG_W-1:0]           cfg_wdata,
  output logic                                 out_valid,
  output logic                                 out_status,
  output logic signed [dssb_pkg::VAL_W-1:0]    out_data,
  output logic [dssb_pkg::POS_W-1:0]           out_position,
  output logic [dssb_pkg::SIZE_W-1:0]          out_size_a,
  output logic [dssb_pkg::SIZE_W-1:0]          out_size_b,
  output logic                                 out_full_res
);

  dssb_pkg::cmd_t  cmd;
  dssb_pkg::stat_t stat;

  dssb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  dssb_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_side      (in_side),
    .in_value     (in_value),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_data     (out_data),
    .out_position (out_position),
    .out_size_a   (out_size_a),
    .out_size_b   (out_size_b),
    .out_full_res (out_full_res)
  );

endmodule

// ----- rtl/dssb_chk.sv -----
module dssb_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 start,
  input logic                                 busy,
  input logic [2:0]                           in_action,
  input logic                                 out_valid,
  input logic                                 out_status,
  input logic signed [dssb_pkg::VAL_W-1:0]    out_data,
  input logic [dssb_pkg::POS_W-1:0]           out_position,
  input logic [dssb_pkg::SIZE_W-1:0]          out_size_a,
  input logic [dssb_pkg::SIZE_W-1:0]          out_size_b
);

  // push and clear requests answer in the next cycle
  a_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_action == dssb_pkg::ACT_PUSH ||
                        in_action == dssb_pkg::ACT_CLEAR)) |=> out_valid)
    else $error("push or clear did not answer in one cycle");

  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result issued while still busy");

  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_data == '0 && out_position == '0))
    else $error("failed request carries data or position");

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((8'(out_size_a) + 8'(out_size_b)) <= 8'(dssb_pkg::DEPTH)))
    else $error("stack sizes exceed the store");

endmodule

bind dual_stack_shared_buffer dssb_chk u_dssb_chk (.*);
